// File: sv/array_mode_finder_defines.svh
// Assertion macros for the array mode finder RTL.
`ifndef ARRAY_MODE_FINDER_DEFINES_SVH
`define ARRAY_MODE_FINDER_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define AMF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define AMF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/amf_pkg.sv
// Shared types and constants for the array mode finder.
package amf_pkg;

	localparam int MAX_ITEMS   = 256;
	localparam int VALUE_W     = 32;
	localparam int IDX_W       = $clog2(MAX_ITEMS);
	localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
	localparam int CHILD_W     = IDX_W + 2;
	localparam int MODE_CNT_W  = 9;
	localparam int OUT_FIELDS_W = VALUE_W + MODE_CNT_W + 1;
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELDS_W;

	typedef logic [VALUE_W-1:0]    value_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [CHILD_W-1:0]    child_t;
	typedef logic [MODE_CNT_W-1:0] mode_cnt_t;

	// RAM access issued by the sort/scan sequencer
	typedef struct packed {
		logic   we;
		idx_t   waddr;
		value_t wdata;
		idx_t   raddr_a;
		idx_t   raddr_b;
	} ram_req_t;

	// Result of one set
	typedef struct packed {
		value_t value;
		cnt_t   count;
	} result_t;

endpackage

// File: sv/amf_ram.sv
// Generic RAM: one write port, two registered read ports.
module amf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: sv/amf_seq.sv
// Heap sort and run-length scan sequencer around two signed comparators.
module amf_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  amf_pkg::cnt_t     n,
	input  amf_pkg::value_t   rdata_a,
	input  amf_pkg::value_t   rdata_b,
	output amf_pkg::ram_req_t ram_req,
	output logic              done,
	output amf_pkg::result_t  result
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_BLD_RD  = 4'd1;
	localparam logic [3:0] ST_BLD_LD  = 4'd2;
	localparam logic [3:0] ST_SIFT_RD = 4'd3;
	localparam logic [3:0] ST_SIFT_CMP = 4'd4;
	localparam logic [3:0] ST_EXT_RD  = 4'd5;
	localparam logic [3:0] ST_EXT_LD  = 4'd6;
	localparam logic [3:0] ST_SCAN_ST = 4'd7;
	localparam logic [3:0] ST_SCAN    = 4'd8;

	logic [3:0]      state_q, state_d;
	logic            extract_q, extract_d;
	amf_pkg::cnt_t   n_q, n_d;
	amf_pkg::cnt_t   k_q, k_d;
	amf_pkg::cnt_t   size_q, size_d;
	amf_pkg::idx_t   root_q, root_d;
	amf_pkg::value_t val_q, val_d;
	amf_pkg::idx_t   j_q, j_d;
	amf_pkg::value_t cur_q, cur_d;
	amf_pkg::cnt_t   cur_cnt_q, cur_cnt_d;
	amf_pkg::value_t best_q, best_d;
	amf_pkg::cnt_t   best_cnt_q, best_cnt_d;
	logic            done_q, done_d;

	amf_pkg::child_t left, right, size_ext;
	logic            has_left, has_right, pick_b, sift_end;
	amf_pkg::value_t pick_val;
	amf_pkg::idx_t   pick_idx;
	amf_pkg::cnt_t   run_cnt;

	// shared comparator path: larger child, then child against sifted value
	assign left     = {1'b0, root_q, 1'b1};
	assign right    = left + amf_pkg::child_t'(1);
	assign size_ext = amf_pkg::child_t'(size_q);
	assign has_left  = left < size_ext;
	assign has_right = right < size_ext;
	assign pick_b   = has_right && ($signed(rdata_b) > $signed(rdata_a));
	assign pick_val = pick_b ? rdata_b : rdata_a;
	assign pick_idx = pick_b ? amf_pkg::idx_t'(right) : amf_pkg::idx_t'(left);
	assign run_cnt  = (j_q == '0 || rdata_a != cur_q) ? amf_pkg::cnt_t'(1)
		: cur_cnt_q + amf_pkg::cnt_t'(1);

	always_comb begin
		state_d    = state_q;
		extract_d  = extract_q;
		n_d        = n_q;
		k_d        = k_q;
		size_d     = size_q;
		root_d     = root_q;
		val_d      = val_q;
		j_d        = j_q;
		cur_d      = cur_q;
		cur_cnt_d  = cur_cnt_q;
		best_d     = best_q;
		best_cnt_d = best_cnt_q;
		done_d     = 1'b0;
		sift_end   = 1'b0;
		ram_req    = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					n_d       = n;
					extract_d = 1'b0;
					k_d       = n >> 1;
					state_d   = (n < amf_pkg::cnt_t'(2)) ? ST_SCAN_ST : ST_BLD_RD;
				end
			end
			ST_BLD_RD: begin
				ram_req.raddr_a = amf_pkg::idx_t'(k_q - amf_pkg::cnt_t'(1));
				root_d  = amf_pkg::idx_t'(k_q - amf_pkg::cnt_t'(1));
				size_d  = n_q;
				state_d = ST_BLD_LD;
			end
			ST_BLD_LD: begin
				val_d   = rdata_a;
				state_d = ST_SIFT_RD;
			end
			ST_SIFT_RD: begin
				ram_req.raddr_a = amf_pkg::idx_t'(left);
				ram_req.raddr_b = amf_pkg::idx_t'(right);
				if (!has_left) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = root_q;
					ram_req.wdata = val_q;
					sift_end      = 1'b1;
				end else begin
					state_d = ST_SIFT_CMP;
				end
			end
			ST_SIFT_CMP: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = root_q;
				if ($signed(pick_val) > $signed(val_q)) begin
					ram_req.wdata = pick_val;
					root_d        = pick_idx;
					state_d       = ST_SIFT_RD;
				end else begin
					ram_req.wdata = val_q;
					sift_end      = 1'b1;
				end
			end
			ST_EXT_RD: begin
				ram_req.raddr_a = '0;
				ram_req.raddr_b = amf_pkg::idx_t'(k_q);
				state_d = ST_EXT_LD;
			end
			ST_EXT_LD: begin
				// heap top moves to the sorted tail, tail value sifts from the root
				ram_req.we    = 1'b1;
				ram_req.waddr = amf_pkg::idx_t'(k_q);
				ram_req.wdata = rdata_a;
				val_d   = rdata_b;
				root_d  = '0;
				size_d  = k_q;
				state_d = ST_SIFT_RD;
			end
			ST_SCAN_ST: begin
				ram_req.raddr_a = '0;
				j_d     = '0;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				ram_req.raddr_a = j_q + amf_pkg::idx_t'(1);
				cur_d     = rdata_a;
				cur_cnt_d = run_cnt;
				if (j_q == '0) begin
					best_d     = rdata_a;
					best_cnt_d = amf_pkg::cnt_t'(1);
				end else if (run_cnt > best_cnt_q) begin
					best_d     = rdata_a;
					best_cnt_d = run_cnt;
				end
				if (amf_pkg::cnt_t'(j_q) == n_q - amf_pkg::cnt_t'(1)) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					j_d = j_q + amf_pkg::idx_t'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (sift_end) begin
			if (!extract_q) begin
				if (k_q == amf_pkg::cnt_t'(1)) begin
					extract_d = 1'b1;
					k_d       = n_q - amf_pkg::cnt_t'(1);
					state_d   = ST_EXT_RD;
				end else begin
					k_d     = k_q - amf_pkg::cnt_t'(1);
					state_d = ST_BLD_RD;
				end
			end else begin
				if (k_q == amf_pkg::cnt_t'(1)) begin
					state_d = ST_SCAN_ST;
				end else begin
					k_d     = k_q - amf_pkg::cnt_t'(1);
					state_d = ST_EXT_RD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			extract_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			extract_q <= extract_d;
			done_q    <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q        <= n_d;
		k_q        <= k_d;
		size_q     <= size_d;
		root_q     <= root_d;
		val_q      <= val_d;
		j_q        <= j_d;
		cur_q      <= cur_d;
		cur_cnt_q  <= cur_cnt_d;
		best_q     <= best_d;
		best_cnt_q <= best_cnt_d;
	end

	assign done         = done_q;
	assign result.value = best_q;
	assign result.count = best_cnt_q;

endmodule

// File: sv/array_mode_finder.sv
// Top level of the array mode finder: load path, sequencer, value RAM and result register.
`include "array_mode_finder_defines.svh"

// array_mode_finder collects signed 32-bit values, one per s_axis transaction,
// into a 256-entry RAM. The transaction with tlast high closes the set: the
// stored values are heap-sorted in place and then scanned once in ascending
// order for the longest run of equal values. One m_axis transaction returns
// that value, its count and an overflow flag; on a tie the smaller value wins.
// Values that arrive while the RAM is full are dropped and set the overflow
// flag, and a tlast transaction still closes the set even when dropped.
// Loading accepts one value per cycle. After tlast, s_axis_tready stays low
// while the heap sort and the scan run; every sift step passes through the
// two signed comparators and the two read ports of the value RAM, which bound
// the sort. A result waiting on m_axis does not block loading or sorting of
// the next set; once that sort is done, s_axis_tready stays low until the
// waiting result has been taken.
module array_mode_finder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [amf_pkg::VALUE_W-1:0]        s_axis_tdata,  // [31:0] value
	input  logic                               s_axis_tlast,  // last of set
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [31:0] mode_value, [40:32] mode_count, [41] overflow, [47:42] zero
	output logic [amf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_SORT  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]          state_q;
	amf_pkg::cnt_t       count_q;
	logic                dropped_q;
	logic                start_q;
	logic                in_xfer, store_full, load_we, out_load;

	amf_pkg::ram_req_t   seq_req;
	amf_pkg::result_t    seq_result;
	logic                seq_done;
	amf_pkg::value_t     rdata_a, rdata_b;

	logic                m_valid_q;
	amf_pkg::value_t     m_value_q;
	amf_pkg::mode_cnt_t  m_count_q;
	logic                m_ovf_q;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign store_full    = (count_q == amf_pkg::cnt_t'(amf_pkg::MAX_ITEMS));
	assign load_we       = in_xfer && !store_full;
	// result register takes the sequencer output once the previous one is gone
	assign out_load      = (state_q == ST_DRAIN) && (!m_valid_q || m_axis_tready);

	// set bookkeeping and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
			start_q   <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (store_full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + amf_pkg::cnt_t'(1);
						end
						if (s_axis_tlast) begin
							start_q <= 1'b1;
							state_q <= ST_SORT;
						end
					end
				end
				ST_SORT: begin
					if (seq_done) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_load) begin
						count_q   <= '0;
						dropped_q <= 1'b0;
						state_q   <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	amf_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.n       (count_q),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b),
		.ram_req (seq_req),
		.done    (seq_done),
		.result  (seq_result)
	);

	// loading owns the write port in ST_LOAD, the sequencer otherwise
	amf_ram #(
		.WIDTH (amf_pkg::VALUE_W),
		.DEPTH (amf_pkg::MAX_ITEMS)
	) u_ram (
		.clk     (clk),
		.we      (load_we || seq_req.we),
		.waddr   (load_we ? amf_pkg::idx_t'(count_q) : seq_req.waddr),
		.wdata   (load_we ? s_axis_tdata : seq_req.wdata),
		.raddr_a (seq_req.raddr_a),
		.raddr_b (seq_req.raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_value_q <= seq_result.value;
			m_count_q <= amf_pkg::mode_cnt_t'(seq_result.count);
			m_ovf_q   <= dropped_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{amf_pkg::OUT_PAD_W{1'b0}}, m_ovf_q, m_count_q, m_value_q};

	`AMF_ASSERT(a_count_range, count_q <= amf_pkg::cnt_t'(amf_pkg::MAX_ITEMS), "item count beyond capacity")
	`AMF_ASSERT(a_drop_full, dropped_q |-> store_full, "drop flagged with room left in store")
	`AMF_ASSERT(a_last_closes, (in_xfer && s_axis_tlast) |=> (state_q == ST_SORT && !s_axis_tready), "set not closed after last")
	`AMF_ASSERT(a_done_in_sort, seq_done |-> (state_q == ST_SORT), "sequencer finished outside sort phase")

endmodule
